// ===== rtl/core/lat_pkg.sv =====
// shared types and constants for the toroidal life engine
package lat_pkg;

  localparam int GRID_WIDTH_DEF  = 128;
  localparam int GRID_HEIGHT_DEF = 128;
  localparam int COORD_W         = 8;
  localparam int GEN_W           = 32;
  localparam int NBR_COUNT       = 8;
  localparam int BIRTH_COUNT     = 3;
  localparam int KEEP_COUNT      = 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_STEP   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic             cell_value;
    logic [GEN_W-1:0] generation;
  } out_item_t;

endpackage

// ===== rtl/core/life_automaton_torus.sv =====
// top level of the toroidal life engine: sequencer, row buffers and grid memory
//
// usage
// - one operation per input transfer (in_valid / in_stall / in_item): clear, toggle
//   a cell, step one generation, or read a cell
// - exactly one result transfer per operation (out_valid / out_stall / out_item)
//   with status, cell value and the wrapped generation count
// - one item at a time: in_stall stays high from acceptance until the result
//   has been transferred
// operations
// - clear: row valid flags drop at once, memory is left alone
// - toggle / read on grid: one row read through the ram
// - step: the single rule unit evaluates one cell per cycle along each row, with a
//   row write-back and a buffer shift between rows
// reset
// - all row valid flags cleared, so every cell reads dead; generation zero;
//   no clearing pass is needed
// stall
// - a stalled result holds in its output register and the block takes
//   nothing new until it has been transferred
module life_automaton_torus #(
  parameter int GRID_WIDTH  = lat_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = lat_pkg::GRID_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lat_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lat_pkg::out_item_t out_item
);

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);
  localparam logic [XW-1:0] XMAX = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0] YMAX = YW'(GRID_HEIGHT - 1);
  localparam logic [lat_pkg::COORD_W-1:0] XLIM = lat_pkg::COORD_W'(GRID_WIDTH);
  localparam logic [lat_pkg::COORD_W-1:0] YLIM = lat_pkg::COORD_W'(GRID_HEIGHT);
  localparam logic [YW:0] HLIM = (YW + 1)'(GRID_HEIGHT);

  typedef logic [GRID_WIDTH-1:0] row_t;

  typedef enum logic [3:0] {
    ST_IDLE,   // waiting for an operation
    ST_ACC,    // toggle / read: row data arrives
    ST_S0,     // step: fetch last row
    ST_S1,     // step: fetch row 0
    ST_S2,     // step: fetch row 1
    ST_S3,     // step: load lower row buffer
    ST_CELL,   // step: one cell per cycle
    ST_WB,     // step: write new row, fetch the row two below
    ST_SHIFT,  // step: slide the three row buffers down
    ST_OUT     // result waits for transfer
  } state_t;

  state_t state_r;

  // request and sequencer registers
  lat_pkg::op_t          req_op_r;
  logic [XW-1:0]         req_x_r;
  logic [YW-1:0]         req_y_r;
  logic [XW-1:0]         x_r;
  logic [YW-1:0]         y_r;
  logic [lat_pkg::GEN_W-1:0] gen_r;
  lat_pkg::out_item_t    out_item_r;

  // row buffers: above, current, below, the saved old row 0 and the row being built
  row_t prev_r;
  row_t cur_r;
  row_t next_r;
  row_t save0_r;
  row_t newrow_r;

  // per-row valid flags: a row never written since clear reads as dead
  logic [GRID_HEIGHT-1:0] row_vld_r;
  logic                   rd_vld_r;

  // ram port signals
  logic          ram_we;
  logic [YW-1:0] ram_waddr;
  row_t          ram_wdata;
  logic          ram_re;
  logic [YW-1:0] ram_raddr;
  row_t          ram_q;
  row_t          rd_row;

  logic          in_xfer;
  logic          req_inside;
  logic [YW:0]   y_plus2;
  logic          far_wrap;

  // window around column x_r
  logic [XW-1:0] col_lf;
  logic [XW-1:0] col_rt;
  logic [lat_pkg::NBR_COUNT-1:0] nbrs;
  logic          cell_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_item  = out_item_r;
  assign in_xfer   = in_valid && !in_stall;

  assign req_inside = (in_item.cell_x < XLIM) && (in_item.cell_y < YLIM);

  // the row two below the current one; past the bottom it is old row 0,
  // which has already been overwritten and lives in save0_r
  assign y_plus2  = {1'b0, y_r} + (YW + 1)'(2);
  assign far_wrap = (y_plus2 >= HLIM);

  assign rd_row = rd_vld_r ? ram_q : '0;

  assign col_lf = (x_r == '0)   ? XMAX   : x_r - XW'(1);
  assign col_rt = (x_r == XMAX) ? XW'(0) : x_r + XW'(1);

  assign nbrs = {prev_r[col_lf], prev_r[x_r], prev_r[col_rt],
                 cur_r[col_lf],               cur_r[col_rt],
                 next_r[col_lf], next_r[x_r], next_r[col_rt]};

  lat_cell_rule u_rule (
    .nbrs     (nbrs),
    .self_bit (cur_r[x_r]),
    .next_bit (cell_nxt)
  );

  // memory port steering
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = y_r;
    ram_wdata = newrow_r;
    case (state_r)
      ST_IDLE: begin
        ram_re    = in_xfer && req_inside &&
                    (in_item.operation == lat_pkg::OP_TOGGLE ||
                     in_item.operation == lat_pkg::OP_READ);
        ram_raddr = in_item.cell_y[YW-1:0];
      end
      ST_ACC: begin
        ram_we    = (req_op_r == lat_pkg::OP_TOGGLE);
        ram_waddr = req_y_r;
        ram_wdata = rd_row ^ (row_t'(1) << req_x_r);
      end
      ST_S0: begin
        ram_re    = 1'b1;
        ram_raddr = YMAX;
      end
      ST_S1: begin
        ram_re    = 1'b1;
        ram_raddr = YW'(0);
      end
      ST_S2: begin
        ram_re    = 1'b1;
        ram_raddr = YW'(1);
      end
      ST_WB: begin
        ram_we    = 1'b1;
        ram_re    = !far_wrap && (y_r != YMAX);
        ram_raddr = y_plus2[YW-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  lat_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_q)
  );

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      gen_r     <= '0;
    end else begin
      if (ram_re) begin
        rd_vld_r <= row_vld_r[ram_raddr];
      end
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            req_op_r <= in_item.operation;
            req_x_r  <= in_item.cell_x[XW-1:0];
            req_y_r  <= in_item.cell_y[YW-1:0];
            out_item_r.cell_value <= 1'b0;
            case (in_item.operation)
              lat_pkg::OP_CLEAR: begin
                row_vld_r             <= '0;
                gen_r                 <= '0;
                out_item_r.status     <= lat_pkg::STATUS_OK;
                out_item_r.generation <= '0;
                state_r               <= ST_OUT;
              end
              lat_pkg::OP_STEP: begin
                // generation is filled in after the last row
                out_item_r.status <= lat_pkg::STATUS_OK;
                state_r           <= ST_S0;
              end
              default: begin
                out_item_r.generation <= gen_r;
                if (req_inside) begin
                  out_item_r.status <= lat_pkg::STATUS_OK;
                  state_r           <= ST_ACC;
                end else begin
                  out_item_r.status <= lat_pkg::STATUS_RANGE;
                  state_r           <= ST_OUT;
                end
              end
            endcase
          end
        end
        ST_ACC: begin
          // toggle reports the flipped value, read the stored one
          out_item_r.cell_value <= rd_row[req_x_r] ^ (req_op_r == lat_pkg::OP_TOGGLE);
          state_r               <= ST_OUT;
        end
        ST_S0: begin
          state_r <= ST_S1;
        end
        ST_S1: begin
          prev_r  <= rd_row;
          state_r <= ST_S2;
        end
        ST_S2: begin
          cur_r   <= rd_row;
          save0_r <= rd_row;
          state_r <= ST_S3;
        end
        ST_S3: begin
          next_r  <= rd_row;
          x_r     <= '0;
          y_r     <= '0;
          state_r <= ST_CELL;
        end
        ST_CELL: begin
          newrow_r[x_r] <= cell_nxt;
          x_r           <= x_r + XW'(1);
          if (x_r == XMAX) begin
            state_r <= ST_WB;
          end
        end
        ST_WB: begin
          if (y_r == YMAX) begin
            gen_r                 <= gen_r + lat_pkg::GEN_W'(1);
            out_item_r.generation <= gen_r + lat_pkg::GEN_W'(1);
            state_r               <= ST_OUT;
          end else begin
            state_r <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          prev_r  <= cur_r;
          cur_r   <= next_r;
          next_r  <= far_wrap ? save0_r : rd_row;
          x_r     <= '0;
          y_r     <= y_r + YW'(1);
          state_r <= ST_CELL;
        end
        ST_OUT: begin
          if (!out_stall) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // a clear reports generation zero in the very next cycle
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_item.operation == lat_pkg::OP_CLEAR
    |=> out_valid && out_item.generation == '0)
    else $error("clear did not report generation zero");

  // the last row write of a step bumps the counter by one
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB && y_r == YMAX |=> gen_r == $past(gen_r) + lat_pkg::GEN_W'(1))
    else $error("generation counter not advanced after step");

  // the grid is only written while an operation is in flight
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r != ST_IDLE && state_r != ST_OUT)
    else $error("grid written outside an operation");

  // an out of range result never carries a live cell
  a_range_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == lat_pkg::STATUS_RANGE |-> !out_item.cell_value)
    else $error("out of range result with cell value set");

  // write and read never hit the same row during a step
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB && ram_re |-> ram_raddr != ram_waddr)
    else $error("step reads a row while writing it");

endmodule

// ===== rtl/core/lat_ram.sv =====
// generic single write port ram with registered read
module lat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/lat_cell_rule.sv =====
// b3/s23 next state of one cell from its neighbor bits
module lat_cell_rule (
  input  logic [lat_pkg::NBR_COUNT-1:0] nbrs,
  input  logic                          self_bit,
  output logic                          next_bit
);

  logic [3:0] live;

  always_comb begin
    live = 4'd0;
    for (int i = 0; i < lat_pkg::NBR_COUNT; i++) begin
      live = live + 4'(nbrs[i]);
    end
    if (live == 4'(lat_pkg::BIRTH_COUNT)) begin
      next_bit = 1'b1;
    end else if (live == 4'(lat_pkg::KEEP_COUNT)) begin
      next_bit = self_bit;
    end else begin
      next_bit = 1'b0;
    end
  end

endmodule
